// ----- rtl/core/bounded_indexed_deque_defines.svh -----
// assertion macros for the bounded indexed deque
// used by the top level only, no other dependencies
`ifndef BOUNDED_INDEXED_DEQUE_DEFINES_SVH
`define BOUNDED_INDEXED_DEQUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bid_pkg.sv -----
// types and constants shared by the bounded indexed deque
// no dependencies
package bid_pkg;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_ENTRY_WIDTH = 32;
   localparam int OP_WIDTH        = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_REM_FRONT = 3'd3,
      OP_REM_BACK  = 3'd4
   } bid_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_PUT,
      ST_TAKE
   } bid_state_type;

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } bid_mem_ctl_type;

endpackage

// ----- rtl/core/bid_ram.sv -----
// single-port-per-direction entry memory with registered read data
// depends on bid_pkg
module bid_ram
   import bid_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int WIDTH = DEF_ENTRY_WIDTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  bid_mem_ctl_type  ctl,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bounded_indexed_deque.sv -----
// bounded deque with indexed insert: an ordered list of up to CAPACITY entries,
// front at place 0. A request is taken when start is high and busy is low; its
// one result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, in the first cycle with busy low after the request, and cannot be
// held off.
// Entries live in a memory with one read and one write per cycle, and a single
// index stepper moves one entry per read/write pair. An insert shifts later
// entries back, then writes the new one; a front remove shifts later entries
// forward; a back remove only reads; a refused request (full, bad position,
// empty, unknown op) keeps busy low. The result word is on the ports in the
// cycle right after the last busy cycle (right after the accepting edge for a
// refused request), and a new request may be taken in that same cycle.
// depends on bid_pkg, bid_ram and bounded_indexed_deque_defines.svh
`include "bounded_indexed_deque_defines.svh"

module bounded_indexed_deque
   import bid_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
   localparam int CW         = $clog2(CAPACITY + 1),
   localparam int AW         = $clog2(CAPACITY)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_WIDTH-1:0]    req_op,
   input  logic [CW-1:0]          req_position,
   input  logic [ENTRY_WIDTH-1:0] req_entry_value,
   output logic                   rsp_strobe,
   output logic                   rsp_ok,
   output logic [ENTRY_WIDTH-1:0] rsp_removed_value,
   output logic [CW-1:0]          rsp_entry_count
);

   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   // control state
   bid_state_type    state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   // working registers
   logic [CW-1:0]    idx_ff, idx_in;      // write address of the current move
   logic [CW-1:0]    stop_ff, stop_in;    // last place the shift reaches
   logic             ins_ff, ins_in;      // shifting toward the back
   logic             front_ff, front_in;  // remove at the front
   logic [ENTRY_WIDTH-1:0] val_ff, val_in;
   logic [ENTRY_WIDTH-1:0] removed_ff, removed_in;

   // result word
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [ENTRY_WIDTH-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;

   // memory port
   bid_mem_ctl_type        mem_ctl;
   logic [AW-1:0]          mem_wr_addr;
   logic [ENTRY_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]          mem_rd_addr;
   logic [ENTRY_WIDTH-1:0] mem_rd_data;

   // shared index stepper: down for an insert shift, up for a front remove
   logic [CW-1:0]          idx_adj;

   assign idx_adj = ins_ff ? (idx_ff - ONE_CNT) : (idx_ff + ONE_CNT);

   bid_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer: next state, datapath loads and memory strobes
   always_comb begin
      logic          do_ins;
      logic          do_rem;
      logic          rem_front;
      logic [CW-1:0] place;

      state_in       = state_ff;
      count_in       = count_ff;
      rsp_strobe_in  = 1'b0;
      idx_in         = idx_ff;
      stop_in        = stop_ff;
      ins_in         = ins_ff;
      front_in       = front_ff;
      val_in         = val_ff;
      removed_in     = removed_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      mem_ctl        = '0;
      mem_wr_addr    = idx_ff[AW-1:0];
      mem_wr_data    = mem_rd_data;
      mem_rd_addr    = idx_adj[AW-1:0];
      do_ins         = 1'b0;
      do_rem         = 1'b0;
      rem_front      = 1'b0;
      place          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in = req_entry_value;
               case (bid_op_type'(req_op))
                  OP_INS_FRONT: begin
                     do_ins = 1'b1;
                     place  = '0;
                  end
                  OP_INS_BACK: begin
                     do_ins = 1'b1;
                     place  = count_ff;
                  end
                  OP_INS_AT: begin
                     do_ins = 1'b1;
                     place  = req_position;
                  end
                  OP_REM_FRONT: begin
                     do_rem    = 1'b1;
                     rem_front = 1'b1;
                  end
                  OP_REM_BACK: begin
                     do_rem = 1'b1;
                  end
                  default: begin
                     do_ins = 1'b0;
                  end
               endcase

               // refused request answers at once with the count unchanged
               rsp_ok_in      = 1'b0;
               rsp_removed_in = '0;
               rsp_count_in   = count_ff;

               if (do_ins && count_ff != CAP_CNT && place <= count_ff) begin
                  idx_in   = count_ff;
                  stop_in  = place;
                  ins_in   = 1'b1;
                  state_in = (count_ff == place) ? ST_PUT : ST_READ;
               end else if (do_rem && count_ff != '0) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = rem_front ? '0 : AW'(count_ff - ONE_CNT);
                  idx_in        = '0;
                  stop_in       = count_ff - ONE_CNT;
                  ins_in        = 1'b0;
                  front_in      = rem_front;
                  state_in      = ST_TAKE;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end

         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_WRITE;
         end

         ST_WRITE: begin
            mem_ctl.wr_en = 1'b1;
            idx_in        = idx_adj;
            if (idx_adj == stop_ff) begin
               if (ins_ff) begin
                  state_in = ST_PUT;
               end else begin
                  // front remove: last entry moved down
                  count_in       = count_ff - ONE_CNT;
                  rsp_strobe_in  = 1'b1;
                  rsp_ok_in      = 1'b1;
                  rsp_removed_in = removed_ff;
                  rsp_count_in   = count_ff - ONE_CNT;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_READ;
            end
         end

         ST_PUT: begin
            mem_ctl.wr_en  = 1'b1;
            mem_wr_addr    = stop_ff[AW-1:0];
            mem_wr_data    = val_ff;
            count_in       = count_ff + ONE_CNT;
            rsp_strobe_in  = 1'b1;
            rsp_ok_in      = 1'b1;
            rsp_removed_in = '0;
            rsp_count_in   = count_ff + ONE_CNT;
            state_in       = ST_IDLE;
         end

         ST_TAKE: begin
            removed_in = mem_rd_data;
            if (front_ff && idx_ff != stop_ff) begin
               state_in = ST_READ;
            end else begin
               // back remove, or the only entry left
               count_in       = count_ff - ONE_CNT;
               rsp_strobe_in  = 1'b1;
               rsp_ok_in      = 1'b1;
               rsp_removed_in = mem_rd_data;
               rsp_count_in   = count_ff - ONE_CNT;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      stop_ff        <= stop_in;
      ins_ff         <= ins_in;
      front_ff       <= front_in;
      val_ff         <= val_in;
      removed_ff     <= removed_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

   // checks

   `BID_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_CNT,
                   "count exceeds capacity")

   `BID_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE,
                   "result word while busy")

   `BID_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy,
                    rsp_strobe_ff || state_ff != ST_IDLE, "request dropped")

   `BID_ASSERT_NOW(a_fail_zero, clock, reset, rsp_strobe_ff && !rsp_ok_ff,
                   rsp_removed_ff == '0 && rsp_count_ff == count_ff,
                   "refused word not clean")

endmodule

// ----- test/tb.sv -----
// testbench for bounded_indexed_deque: directed corner cases, then random traffic
// depends on bid_pkg and the bounded_indexed_deque rtl
`timescale 1ns / 100ps

module tb
   import bid_pkg::*;
();

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int ENTRY_WIDTH  = DEF_ENTRY_WIDTH;
   localparam int CW           = $clog2(CAPACITY + 1);
   localparam int RESET_CYCLES = 2;
   // settle time covers the longest busy stretch plus the result word
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
   localparam int CYCLE_LIMIT   = 400000;

   // op codes the block does not decode; they are refused with no state change
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_A = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_B = 3'd6;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_C = 3'd7;

   // one result word as the rsp_ ports carry it
   typedef struct packed {
      logic                   ok;
      logic [ENTRY_WIDTH-1:0] removed_value;
      logic [CW-1:0]          entry_count;
   } deque_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OP_WIDTH-1:0]    req_op = '0;
   logic [CW-1:0]          req_position = '0;
   logic [ENTRY_WIDTH-1:0] req_entry_value = '0;
   logic                   rsp_strobe;
   logic                   rsp_ok;
   logic [ENTRY_WIDTH-1:0] rsp_removed_value;
   logic [CW-1:0]          rsp_entry_count;

   // our own copy of the list, front at index 0
   logic [ENTRY_WIDTH-1:0] deque_model[$];
   // result words predicted but not yet seen, oldest first
   deque_result_type       expected_words[$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   // chance in percent that the sender idles after a word
   int                     sender_idle_pct = 31;

   bounded_indexed_deque #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_entry_value   (req_entry_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // applies one accepted request word to the list copy and returns its result
   function automatic deque_result_type predict_deque_word(
      input logic [OP_WIDTH-1:0]    op,
      input logic [CW-1:0]          pos,
      input logic [ENTRY_WIDTH-1:0] val
   );
      deque_result_type res;
      int               place;
      res   = '0;
      place = -1;
      case (op)
         OP_INS_FRONT: place = 0;
         OP_INS_BACK:  place = deque_model.size();
         OP_INS_AT:    place = pos;
         OP_REM_FRONT: begin
            if (deque_model.size() != 0) begin
               res.ok            = 1'b1;
               res.removed_value = deque_model.pop_front();
            end
         end
         OP_REM_BACK: begin
            // a single held entry leaves the list empty
            if (deque_model.size() != 0) begin
               res.ok            = 1'b1;
               res.removed_value = deque_model.pop_back();
            end
         end
         default: ;
      endcase
      // inserts fail on a full list or a place past the back
      if (place >= 0 && deque_model.size() < CAPACITY && place <= deque_model.size()) begin
         deque_model.insert(place, val);
         res.ok = 1'b1;
      end
      res.entry_count = CW'(deque_model.size());
      return res;
   endfunction

   // drives one request word, waits until it is taken, then maybe idles;
   // start is left high when the next word follows straight away
   task automatic send_word(
      input logic [OP_WIDTH-1:0]    op,
      input logic [CW-1:0]          pos,
      input logic [ENTRY_WIDTH-1:0] val
   );
      int gap;
      req_op          <= op;
      req_position    <= pos;
      req_entry_value <= val;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // taken at this edge: busy was low before it
      expected_words.push_back(predict_deque_word(op, pos, val));
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(6, 1);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every predicted word has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // every result word is matched against the oldest prediction
   always @(posedge clock) begin : check_results
      deque_result_type due;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            due = expected_words.pop_front();
            if (rsp_ok !== due.ok) begin
               $error("rsp_ok mismatch: expected %0d, got %0d", due.ok, rsp_ok);
               error_count++;
            end
            if (rsp_removed_value !== due.removed_value) begin
               $error("rsp_removed_value mismatch: expected %h, got %h",
                      due.removed_value, rsp_removed_value);
               error_count++;
            end
            if (rsp_entry_count !== due.entry_count) begin
               $error("rsp_entry_count mismatch: expected %0d, got %0d",
                      due.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // removes and out-of-range inserts on an empty list, plus undecoded ops
   task automatic test_empty_refusals();
      send_word(OP_REM_FRONT, '0, $urandom());
      send_word(OP_REM_BACK, '0, $urandom());
      send_word(OP_INS_AT, CW'(1), $urandom());
      send_word(OP_UNUSED_A, '0, $urandom());
      send_word(OP_UNUSED_B, '1, '1);
      send_word(OP_UNUSED_C, '0, '0);
   endtask

   // one entry in and out again from either end
   task automatic test_single_entry();
      send_word(OP_INS_AT, CW'(0), '1);
      send_word(OP_REM_BACK, '0, '0);
      send_word(OP_INS_FRONT, '1, '0);
      send_word(OP_REM_FRONT, '1, '1);
   endtask

   // indexed insert at the back, past the back, far past it, and at the front
   task automatic test_position_limits();
      send_word(OP_INS_BACK, '0, 32'h0000_0001);
      send_word(OP_INS_AT, CW'(1), 32'hA5A5_5A5A);
      send_word(OP_INS_AT, CW'(3), $urandom());
      send_word(OP_INS_AT, '1, $urandom());
      send_word(OP_INS_AT, CW'(0), 32'h8000_0000);
   endtask

   // fill to capacity, then every kind of insert must be refused
   task automatic test_full_list();
      while (deque_model.size() < CAPACITY) send_word(OP_INS_BACK, '0, $urandom());
      send_word(OP_INS_FRONT, '0, $urandom());
      send_word(OP_INS_BACK, '0, $urandom());
      send_word(OP_INS_AT, CW'(CAPACITY), $urandom());
      send_word(OP_INS_AT, CW'(0), $urandom());
   endtask

   // random traffic; the insert share drifts every few dozen words so the list
   // swings between empty and full, and a few undecoded ops are mixed in
   task automatic test_random_traffic(input int n_words, input int idle_pct);
      int                     done_ops;
      int                     ins_bias;
      logic [OP_WIDTH-1:0]    op;
      logic [CW-1:0]          pos;
      logic [ENTRY_WIDTH-1:0] val;
      sender_idle_pct = idle_pct;
      done_ops = 0;
      ins_bias = 50;
      while (done_ops < n_words) begin
         if (done_ops % 40 == 0) begin
            case ($urandom_range(2))
               0:       ins_bias = 20;
               1:       ins_bias = 50;
               default: ins_bias = 85;
            endcase
         end
         if ($urandom_range(99) < 4) begin
            case ($urandom_range(2))
               0:       op = OP_UNUSED_A;
               1:       op = OP_UNUSED_B;
               default: op = OP_UNUSED_C;
            endcase
         end else if ($urandom_range(99) < ins_bias) begin
            case ($urandom_range(2))
               0:       op = OP_INS_FRONT;
               1:       op = OP_INS_BACK;
               default: op = OP_INS_AT;
            endcase
         end else begin
            op = $urandom_range(1) ? OP_REM_FRONT : OP_REM_BACK;
         end
         // mostly a legal place, sometimes any 5-bit value
         if ($urandom_range(9) < 8) pos = CW'($urandom_range(deque_model.size(), 0));
         else pos = CW'($urandom());
         case ($urandom_range(9))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom();
         endcase
         send_word(op, pos, val);
         if (op <= OP_REM_BACK) done_ops++;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_refusals();
      test_single_entry();
      test_position_limits();
      test_full_list();
      // let the pipe run dry once before the random part
      wait_for_results();

      test_random_traffic(500, 31);
      wait_for_results();
      test_random_traffic(500, 50);
      test_random_traffic(500, 0);

      wait_for_results();
      // room for a stray late word to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
